>>> src/kst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// Shared constants, codes and controller/datapath interface types for the
// keyed slot table.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int CMD_W  = 2;
  localparam int KEY_W  = 16;
  localparam int PAY_W  = 32;
  localparam int CAT_W  = 2;
  localparam int STS_W  = 2;
  localparam int SLOT_W = 6;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd3;

  localparam logic [STS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STS_W-1:0] ST_BAD  = 2'd2;

  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct packed {
    logic load;
    logic scan;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic last;
  } sts_t;

endpackage

>>> src/keyed_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_table
// Keyed table of slots: insert into first free slot, lookup, remove, next key.
//
// Usage:
//   A request (cmd, key, payload, category) is taken on a clock edge where
//   start is high and busy is low. busy rises on the following cycle.
//   Each request scans every slot, one per cycle through the key memory
//   read port, then passes a drain state and a finish state. The result
//   (status, slot, next_key) is shown with done high for exactly one
//   cycle, registered from the finish state. busy is already low in the done
//   cycle, so a new request may be taken there, but none while busy is high.
//   The receiver cannot hold results off; each result must be captured in
//   its done cycle. Outputs hold their last value otherwise.
//   Reset (rst, synchronous) empties the table, clears the valid and written
//   flags and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module keyed_slot_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [kst_pkg::CMD_W-1:0]   cmd,
  input  logic [kst_pkg::KEY_W-1:0]   key,
  input  logic [kst_pkg::PAY_W-1:0]   payload,
  input  logic [kst_pkg::CAT_W-1:0]   category,
  output logic                        done,
  output logic [kst_pkg::STS_W-1:0]   status,
  output logic [kst_pkg::SLOT_W-1:0]  slot,
  output logic [kst_pkg::KEY_W-1:0]   next_key
);
  import kst_pkg::*;

  ctl_t ctl;
  sts_t sts;

  kst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  kst_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .cmd      (cmd),
    .key      (key),
    .payload  (payload),
    .category (category),
    .done     (done),
    .status   (status),
    .slot     (slot),
    .next_key (next_key)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but not busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_MISS || status == ST_BAD))
    else $error("bad status code");

  a_next_key_ok: assert property (@(posedge clk) disable iff (rst)
    (done && next_key != '0) |-> (status == ST_OK && slot == '0))
    else $error("next key with non-ok status");

endmodule

>>> src/kst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_ctrl
// Request sequencer: load, slot scan, pipeline drain, finish.
// ----------------------------------------------------------------------------
module kst_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  kst_pkg::sts_t sts,
  output kst_pkg::ctl_t ctl
);
  import kst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        ctl.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/kst_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_dp
// Slot storage, scan pipeline (one slot per cycle), result formation.
// ----------------------------------------------------------------------------
module kst_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  kst_pkg::ctl_t               ctl,
  output kst_pkg::sts_t               sts,
  input  logic [kst_pkg::CMD_W-1:0]   cmd,
  input  logic [kst_pkg::KEY_W-1:0]   key,
  input  logic [kst_pkg::PAY_W-1:0]   payload,
  input  logic [kst_pkg::CAT_W-1:0]   category,
  output logic                        done,
  output logic [kst_pkg::STS_W-1:0]   status,
  output logic [kst_pkg::SLOT_W-1:0]  slot,
  output logic [kst_pkg::KEY_W-1:0]   next_key
);
  import kst_pkg::*;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [PAY_W-1:0] pay_mem [TABLE_DEPTH];
  logic [CAT_W-1:0] cat_mem [TABLE_DEPTH];

  logic [TABLE_DEPTH-1:0] valid;
  logic [TABLE_DEPTH-1:0] written;

  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [PAY_W-1:0] payload_q;
  logic [CAT_W-1:0] cat_q;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_d;
  logic             pv;
  logic [KEY_W-1:0] key_rd;
  logic             found;
  logic [IDX_W-1:0] hit;
  logic [KEY_W-1:0] top;

  logic [KEY_W-1:0] eff_key;
  logic             match;
  logic             arg_bad;
  logic             do_ins;
  logic             do_rem;
  logic [STS_W-1:0] status_next;
  logic [SLOT_W-1:0] slot_next;
  logic [KEY_W-1:0] next_key_next;

  assign sts.last = (idx == IDX_W'(TABLE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q     <= cmd;
      key_q     <= key;
      payload_q <= payload;
      cat_q     <= category;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      idx <= '0;
    end else if (ctl.scan) begin
      idx <= idx + 1'b1;
    end
    key_rd <= key_mem[idx];
    idx_d  <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= ctl.scan;
    end
  end

  // never-written keys read as zero
  assign eff_key = written[idx_d] ? key_rd : '0;

  always_comb begin
    if (cmd_q == CMD_INSERT) begin
      match = !valid[idx_d];
    end else begin
      match = valid[idx_d] && (key_rd == key_q) && (key_q != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      found <= 1'b0;
      hit   <= '0;
      top   <= '0;
    end else if (pv) begin
      if (!found && match) begin
        found <= 1'b1;
        hit   <= idx_d;
      end
      if (eff_key > top) begin
        top <= eff_key;
      end
    end
  end

  assign arg_bad = (key_q == '0) || (cat_q == '0);
  assign do_ins  = ctl.fin && (cmd_q == CMD_INSERT) && !arg_bad && found;
  assign do_rem  = ctl.fin && (cmd_q == CMD_REMOVE) && found;

  always_comb begin
    status_next   = ST_OK;
    slot_next     = '0;
    next_key_next = '0;
    case (cmd_q)
      CMD_INSERT: begin
        if (arg_bad) begin
          status_next = ST_BAD;
        end else if (!found) begin
          status_next = ST_MISS;
        end else begin
          slot_next = SLOT_W'(hit);
        end
      end
      CMD_LOOKUP, CMD_REMOVE: begin
        if (!found) begin
          status_next = ST_MISS;
        end else begin
          slot_next = SLOT_W'(hit);
        end
      end
      CMD_NEXT: begin
        if (top == KEY_MAX) begin
          status_next = ST_BAD;
        end else begin
          next_key_next = top + 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      written <= '0;
      done    <= 1'b0;
    end else begin
      done <= ctl.fin;
      if (do_ins) begin
        valid[hit]   <= 1'b1;
        written[hit] <= 1'b1;
      end else if (do_rem) begin
        valid[hit] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      key_mem[hit] <= key_q;
      pay_mem[hit] <= payload_q;
      cat_mem[hit] <= cat_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      status   <= status_next;
      slot     <= slot_next;
      next_key <= next_key_next;
    end
  end

endmodule
